/* design/qepc_pkg.sv */
// Shared constants, codes and types for the quadrature encoder period counter.
package qepc_pkg;

    localparam int CHANNELS = 2;
    localparam int CH_W     = 1;
    localparam int TS_W     = 32;
    localparam int CFG_W    = 10;
    localparam int IDX_W    = 1;

    // command codes
    localparam logic [1:0] CMD_EDGE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_REV_POL = 1'b0;
    localparam logic [IDX_W-1:0] REG_CPM     = 1'b1;

    // limit widths for cycles_per_microsecond up to 1023
    localparam int LIM250_W  = 18;
    localparam int LIM500_W  = 19;
    localparam int LIMHALF_W = 29;

    localparam int CPM_RESET = 600;
    localparam logic [LIM250_W-1:0]  LIM250_RESET  = LIM250_W'(CPM_RESET * 250);
    localparam logic [LIM500_W-1:0]  LIM500_RESET  = LIM500_W'(CPM_RESET * 500);
    localparam logic [LIMHALF_W-1:0] LIMHALF_RESET = LIMHALF_W'(CPM_RESET * 500000);

    typedef struct packed {
        logic [LIM250_W-1:0]  lim250;
        logic [LIM500_W-1:0]  lim500;
        logic [LIMHALF_W-1:0] lim_half;
    } t_limits;

    typedef struct packed {
        logic [TS_W-1:0] count;
        logic [TS_W-1:0] tick_last;
        logic [TS_W-1:0] last_time;
        logic [TS_W-1:0] period;
        logic            timeout;
        logic            dir;
    } t_chan_state;

    typedef struct packed {
        logic [1:0]      command;
        logic [CH_W-1:0] channel;
        logic            edge_on_a;
        logic            level_a;
        logic            level_b;
        logic [TS_W-1:0] timestamp;
    } t_in_word;

    typedef struct packed {
        logic [CH_W-1:0]        out_channel;
        logic                   reverse_dir;
        logic [TS_W-1:0]        position_count;
        logic [TS_W-1:0]        edge_period;
        logic [TS_W-1:0]        speed_period;
        logic signed [TS_W-1:0] count_delta;
        logic                   timed_out;
    } t_res_word;

endpackage

/* design/qepc_in_if.sv */
// Input channel: command words with valid/ready handshake.
interface qepc_in_if;
    import qepc_pkg::*;

    logic            valid;
    logic            ready;
    logic [1:0]      command;
    logic [CH_W-1:0] channel;
    logic            edge_on_a;
    logic            level_a;
    logic            level_b;
    logic [TS_W-1:0] timestamp;

    modport source (output valid, command, channel, edge_on_a, level_a, level_b, timestamp,
                    input ready);
    modport sink   (input valid, command, channel, edge_on_a, level_a, level_b, timestamp,
                    output ready);
endinterface

/* design/qepc_out_if.sv */
// Result channel: per-channel report words with valid/ready handshake.
interface qepc_out_if;
    import qepc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CH_W-1:0]        out_channel;
    logic                   reverse_dir;
    logic [TS_W-1:0]        position_count;
    logic [TS_W-1:0]        edge_period;
    logic [TS_W-1:0]        speed_period;
    logic signed [TS_W-1:0] count_delta;
    logic                   timed_out;

    modport source (output valid, out_channel, reverse_dir, position_count, edge_period,
                    speed_period, count_delta, timed_out, input ready);
    modport sink   (input valid, out_channel, reverse_dir, position_count, edge_period,
                    speed_period, count_delta, timed_out, output ready);
endinterface

/* design/quadrature_encoder_period_counter.sv */
// Top level of the quadrature encoder period counter: pipeline, channel state, config.
//
//  channel   | dir | handshake     | word
//  ----------+-----+---------------+-------------------------------------------
//  i_in      | in  | valid/ready   | command, channel, pins, timestamp
//  o_res     | out | valid/ready   | channel report (count, periods, delta)
//  i_cfg_*   | in  | write enable  | reverse polarity, cycles per microsecond
//
// One word per cycle while the result side is not stalled; a taken command loads the
// input register, and the result register is loaded from it when the result side moves,
// the per-channel state update sitting between them. Synchronous active-low reset
// clears all channel state and loads default limits. A stalled result holds the
// result register; the input register still takes one more word before ready drops.
module quadrature_encoder_period_counter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [qepc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [qepc_pkg::CFG_W-1:0]   i_cfg_wdata,
    qepc_in_if.sink                      i_in,
    qepc_out_if.source                   o_res
);
    import qepc_pkg::*;

    logic        r_in_valid;
    t_in_word    r_in;
    logic        r_out_valid;
    t_res_word   r_out;
    logic        r_rev_pol;
    t_limits     r_lim;
    t_chan_state r_state [CHANNELS];
    t_chan_state n_state [CHANNELS];

    logic        accept;
    logic        move;
    logic        fire;
    t_chan_state sel_state;
    t_chan_state upd_state;
    t_chan_state res_state;
    logic [TS_W-1:0] upd_speed;
    logic [TS_W-1:0] upd_delta;
    t_res_word   n_out;

    assign move   = !r_out_valid || o_res.ready;
    assign fire   = r_in_valid && move;
    assign i_in.ready = !r_in_valid || move;
    assign accept = i_in.valid && i_in.ready;

    assign sel_state = r_state[r_in.channel];

    qepc_update u_update (
        .i_command   (r_in.command),
        .i_edge_on_a (r_in.edge_on_a),
        .i_level_a   (r_in.level_a),
        .i_level_b   (r_in.level_b),
        .i_timestamp (r_in.timestamp),
        .i_rev_pol   (r_rev_pol),
        .i_lim       (r_lim),
        .i_state     (sel_state),
        .o_state     (upd_state),
        .o_speed     (upd_speed),
        .o_delta     (upd_delta)
    );

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_state[c] = r_state[c];
            if (fire) begin
                if (r_in.command == CMD_CLEAR) begin
                    n_state[c].count     = '0;
                    n_state[c].tick_last = '0;
                end else if (r_in.channel == CH_W'(c)) begin
                    n_state[c] = upd_state;
                end
            end
        end
    end

    assign res_state = n_state[r_in.channel];

    always_comb begin
        n_out.out_channel    = r_in.channel;
        n_out.reverse_dir    = res_state.dir;
        n_out.position_count = res_state.count;
        n_out.edge_period    = res_state.period;
        n_out.speed_period   = upd_speed;
        n_out.count_delta    = upd_delta;
        n_out.timed_out      = res_state.timeout;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rev_pol   <= 1'b0;
            r_lim       <= '{lim250: LIM250_RESET, lim500: LIM500_RESET,
                             lim_half: LIMHALF_RESET};
            for (int c = 0; c < CHANNELS; c++) begin
                r_state[c] <= '0;
            end
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= r_in_valid;
            end
            for (int c = 0; c < CHANNELS; c++) begin
                r_state[c] <= n_state[c];
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_REV_POL: r_rev_pol <= i_cfg_wdata[0];
                    REG_CPM: begin
                        // precompute 250 us, 500 us and half-second limits
                        r_lim.lim250   <= LIM250_W'(i_cfg_wdata * 18'd250);
                        r_lim.lim500   <= LIM500_W'(i_cfg_wdata * 19'd500);
                        r_lim.lim_half <= LIMHALF_W'(i_cfg_wdata * 29'd500000);
                    end
                    default: r_rev_pol <= r_rev_pol;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.command   <= i_in.command;
            r_in.channel   <= i_in.channel;
            r_in.edge_on_a <= i_in.edge_on_a;
            r_in.level_a   <= i_in.level_a;
            r_in.level_b   <= i_in.level_b;
            r_in.timestamp <= i_in.timestamp;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.out_channel    = r_out.out_channel;
    assign o_res.reverse_dir    = r_out.reverse_dir;
    assign o_res.position_count = r_out.position_count;
    assign o_res.edge_period    = r_out.edge_period;
    assign o_res.speed_period   = r_out.speed_period;
    assign o_res.count_delta    = r_out.count_delta;
    assign o_res.timed_out      = r_out.timed_out;

endmodule

/* design/qepc_update.sv */
// Next-state and report logic for one channel on an edge or tick command.
module qepc_update (
    input  logic [1:0]                 i_command,
    input  logic                       i_edge_on_a,
    input  logic                       i_level_a,
    input  logic                       i_level_b,
    input  logic [qepc_pkg::TS_W-1:0]  i_timestamp,
    input  logic                       i_rev_pol,
    input  qepc_pkg::t_limits          i_lim,
    input  qepc_pkg::t_chan_state      i_state,
    output qepc_pkg::t_chan_state      o_state,
    output logic [qepc_pkg::TS_W-1:0]  o_speed,
    output logic [qepc_pkg::TS_W-1:0]  o_delta
);
    import qepc_pkg::*;

    logic            down;
    logic [TS_W-1:0] interval;
    logic [TS_W-1:0] sum4;
    logic [TS_W-1:0] sum2;
    logic            below250;
    logic            below500;
    logic            tick_to;

    assign down     = (i_edge_on_a ? (i_level_a == i_level_b) : (i_level_a != i_level_b))
                      ^ i_rev_pol;
    assign interval = i_timestamp - i_state.last_time;
    // 3p + interval with wrap, then drop two bits
    assign sum4     = {i_state.period[TS_W-2:0], 1'b0} + i_state.period + interval;
    assign sum2     = i_state.period + interval;
    assign below250 = interval < {{(TS_W-LIM250_W){1'b0}}, i_lim.lim250};
    assign below500 = interval < {{(TS_W-LIM500_W){1'b0}}, i_lim.lim500};
    assign tick_to  = i_state.timeout
                      | (interval > {{(TS_W-LIMHALF_W){1'b0}}, i_lim.lim_half});

    always_comb begin
        o_state = i_state;
        o_speed = '0;
        o_delta = '0;
        case (i_command)
            CMD_EDGE: begin
                o_state.dir       = down;
                o_state.last_time = i_timestamp;
                o_state.count     = down ? i_state.count - 1'b1 : i_state.count + 1'b1;
                if (i_state.timeout) begin
                    o_state.period  = '0;
                    o_state.timeout = 1'b0;
                end else if (below250) begin
                    o_state.period = {2'b00, sum4[TS_W-1:2]};
                end else if (below500) begin
                    o_state.period = {1'b0, sum2[TS_W-1:1]};
                end else begin
                    o_state.period = interval;
                end
            end
            CMD_TICK: begin
                o_state.timeout   = tick_to;
                o_state.tick_last = i_state.count;
                o_delta           = i_state.count - i_state.tick_last;
                if (!tick_to && (i_state.period != '0)) begin
                    o_speed = (interval > i_state.period) ? interval : i_state.period;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

/* design/qepc_checker.sv */
// Port-level checks for the quadrature encoder period counter, bound to the top level.
module qepc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        i_ready,
    input logic [qepc_pkg::TS_W-1:0]   i_speed_period,
    input logic [qepc_pkg::TS_W-1:0]   i_edge_period,
    input logic                        i_timed_out
);
    import qepc_pkg::*;

    // hold a stalled result word
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result word dropped while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // a timed-out channel reports no speed
    a_timeout_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_timed_out |-> i_speed_period == '0)
        else $error("speed reported on timed-out channel");

    // speed period is never shorter than the edge period
    a_speed_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_speed_period != '0) |-> i_speed_period >= i_edge_period)
        else $error("speed period below edge period");

endmodule

bind quadrature_encoder_period_counter qepc_checker u_qepc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_speed_period (o_res.speed_period),
    .i_edge_period  (o_res.edge_period),
    .i_timed_out    (o_res.timed_out)
);

/* tb/tb_quadrature_encoder_period_counter.sv */
// Self-checking testbench for the quadrature encoder period counter: random and directed words.
module tb_quadrature_encoder_period_counter;
    import qepc_pkg::*;

    localparam int          PHASES       = 6;
    localparam int          RANDOM_WORDS = 280;
    localparam logic [1:0]  CMD_SPARE    = 2'd3;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_wdata;

    qepc_in_if  in_if ();
    qepc_out_if res_if ();

    quadrature_encoder_period_counter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_res       (res_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predicted per-channel encoder state and register copies
    logic [31:0]      pos_count   [CHANNELS];
    logic [31:0]      tick_mark   [CHANNELS];
    logic [31:0]      edge_stamp  [CHANNELS];
    logic [31:0]      period_est  [CHANNELS];
    logic             stalled     [CHANNELS];
    logic             count_down  [CHANNELS];
    logic             cfg_rev_pol;
    logic [CFG_W-1:0] cfg_cpm;

    // stimulus generator state
    logic [31:0] gen_edge_ts [CHANNELS];
    logic        gen_la      [CHANNELS];
    logic        gen_lb      [CHANNELS];
    int          gen_ch;

    t_in_word    word_q   [$];
    t_res_word   report_q [$];
    t_in_word    cur_word;
    int unsigned words_taken;
    int unsigned mismatches;
    int unsigned send_idle;
    int unsigned recv_idle;

    function automatic t_res_word encoder_report(input t_in_word w);
        t_res_word   r;
        int          ch;
        logic        down;
        logic [31:0] ivl;
        logic [31:0] elapsed;
        logic [63:0] lim250;
        logic [63:0] lim500;
        logic [63:0] lim_half;
        r        = '0;
        ch       = w.channel;
        lim250   = 64'(cfg_cpm) * 250;
        lim500   = 64'(cfg_cpm) * 500;
        lim_half = 64'(cfg_cpm) * 500000;
        r.out_channel = w.channel;
        case (w.command)
            CMD_EDGE: begin
                down = w.edge_on_a ? (w.level_a == w.level_b) : (w.level_a != w.level_b);
                if (cfg_rev_pol)
                    down = !down;
                count_down[ch] = down;
                ivl            = w.timestamp - edge_stamp[ch];
                edge_stamp[ch] = w.timestamp;
                // first edge after a timeout restarts the estimate
                if (stalled[ch]) begin
                    period_est[ch] = 32'd0;
                    stalled[ch]    = 1'b0;
                end else if (64'(ivl) < lim250) begin
                    period_est[ch] = (period_est[ch] * 32'd3 + ivl) / 32'd4;
                end else if (64'(ivl) < lim500) begin
                    period_est[ch] = (period_est[ch] + ivl) / 32'd2;
                end else begin
                    period_est[ch] = ivl;
                end
                pos_count[ch] = down ? pos_count[ch] - 32'd1 : pos_count[ch] + 32'd1;
            end
            CMD_TICK: begin
                elapsed = w.timestamp - edge_stamp[ch];
                if (64'(elapsed) > lim_half)
                    stalled[ch] = 1'b1;
                if (!stalled[ch] && period_est[ch] != 32'd0)
                    r.speed_period = (elapsed > period_est[ch]) ? elapsed : period_est[ch];
                r.count_delta = pos_count[ch] - tick_mark[ch];
                tick_mark[ch] = pos_count[ch];
            end
            CMD_CLEAR: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    pos_count[i] = 32'd0;
                    tick_mark[i] = 32'd0;
                end
            end
            default: ;
        endcase
        r.reverse_dir    = count_down[ch];
        r.position_count = pos_count[ch];
        r.edge_period    = period_est[ch];
        r.timed_out      = stalled[ch];
        return r;
    endfunction

    function automatic void push_word(input logic [1:0] cmd, input int ch, input logic on_a,
                                      input logic la, input logic lb, input logic [31:0] ts);
        t_in_word w;
        w.command   = cmd;
        w.channel   = ch[CH_W-1:0];
        w.edge_on_a = on_a;
        w.level_a   = la;
        w.level_b   = lb;
        w.timestamp = ts;
        word_q.push_back(w);
        if (cmd == CMD_EDGE)
            gen_edge_ts[ch] = ts;
    endfunction

    // interval since the channel's last edge, biased toward the averaging and timeout limits
    function automatic logic [31:0] pick_interval();
        int unsigned l250;
        int unsigned l500;
        int unsigned lhalf;
        int unsigned pick;
        logic [31:0] marks [6];
        l250  = 32'(cfg_cpm) * 250;
        l500  = 32'(cfg_cpm) * 500;
        lhalf = 32'(cfg_cpm) * 500000;
        marks = '{l250 - 1, l250, l500 - 1, l500, lhalf, lhalf + 1};
        pick  = $urandom_range(99);
        if (pick < 30)
            return $urandom_range(l250);
        else if (pick < 50)
            return $urandom_range(l500, l250);
        else if (pick < 62)
            return marks[$urandom_range(5)];
        else if (pick < 80)
            return $urandom_range(lhalf, l500);
        else if (pick < 88)
            return lhalf + $urandom_range(lhalf);
        else if (pick < 94)
            return $urandom_range(50);
        else
            return $urandom();
    endfunction

    function automatic void random_word();
        int unsigned pick;
        int          ch;
        logic        on_a;
        logic [31:0] ivl;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 30)
            gen_ch = $urandom_range(CHANNELS - 1);
        ch   = gen_ch;
        ivl  = pick_interval();
        on_a = 1'($urandom_range(1));
        if (pick < 58) begin
            // mostly a clean quadrature step: one pin toggles per edge
            if ($urandom_range(9) == 0) begin
                gen_la[ch] = 1'($urandom_range(1));
                gen_lb[ch] = 1'($urandom_range(1));
            end else if (on_a) begin
                gen_la[ch] = ~gen_la[ch];
            end else begin
                gen_lb[ch] = ~gen_lb[ch];
            end
            push_word(CMD_EDGE, ch, on_a, gen_la[ch], gen_lb[ch], gen_edge_ts[ch] + ivl);
        end else if (pick < 84) begin
            push_word(CMD_TICK, ch, on_a, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      gen_edge_ts[ch] + ivl);
        end else if (pick < 89) begin
            push_word(CMD_CLEAR, ch, on_a, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      $urandom());
        end else if (pick < 93) begin
            push_word(CMD_SPARE, ch, on_a, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      $urandom());
        end else begin
            push_word(2'($urandom()), $urandom_range(CHANNELS - 1), on_a,
                      1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
        end
    endfunction

    task automatic wait_idle();
        while (word_q.size() != 0 || report_q.size() != 0 || in_if.valid)
            @(posedge i_clk);
    endtask

    task automatic write_config(input logic rev, input logic [CFG_W-1:0] cpm);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_REV_POL;
        i_cfg_wdata <= CFG_W'(rev);
        @(posedge i_clk);
        i_cfg_idx   <= REG_CPM;
        i_cfg_wdata <= cpm;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_rev_pol = rev;
        cfg_cpm     = cpm;
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always_comb begin
        if (words_taken < 570) begin
            send_idle = 34;
            recv_idle = 55;
        end else if (words_taken < 1140) begin
            send_idle = 55;
            recv_idle = 34;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
    end

    always @(posedge i_clk) begin : drive_words
        t_in_word w;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                report_q.push_back(encoder_report(cur_word));
                words_taken++;
            end
            // hold a word until it is taken
            if (!in_if.valid || in_if.ready) begin
                if (word_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    w                = word_q.pop_front();
                    cur_word         = w;
                    in_if.valid     <= 1'b1;
                    in_if.command   <= w.command;
                    in_if.channel   <= w.channel;
                    in_if.edge_on_a <= w.edge_on_a;
                    in_if.level_a   <= w.level_a;
                    in_if.level_b   <= w.level_b;
                    in_if.timestamp <= w.timestamp;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_reports
        t_res_word want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (report_q.size() == 0) begin
                    $display("%0t: report with nothing expected, expected none actual ch %0d",
                             $time, res_if.out_channel);
                    mismatches++;
                end else begin
                    want = report_q.pop_front();
                    check_field("out_channel", want.out_channel, res_if.out_channel);
                    check_field("reverse_dir", want.reverse_dir, res_if.reverse_dir);
                    check_field("position_count", want.position_count, res_if.position_count);
                    check_field("edge_period", want.edge_period, res_if.edge_period);
                    check_field("speed_period", want.speed_period, res_if.speed_period);
                    check_field("count_delta", want.count_delta, res_if.count_delta);
                    check_field("timed_out", want.timed_out, res_if.timed_out);
                end
            end
            res_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin : run_test
        logic [CFG_W-1:0] cpm;
        in_if.valid     = 1'b0;
        in_if.command   = CMD_EDGE;
        in_if.channel   = '0;
        in_if.edge_on_a = 1'b0;
        in_if.level_a   = 1'b0;
        in_if.level_b   = 1'b0;
        in_if.timestamp = '0;
        res_if.ready    = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_REV_POL;
        i_cfg_wdata     = '0;
        words_taken     = 0;
        mismatches      = 0;
        cfg_rev_pol     = 1'b0;
        cfg_cpm         = CFG_W'(CPM_RESET);
        gen_ch          = 0;
        for (int i = 0; i < CHANNELS; i++) begin
            pos_count[i]   = '0;
            tick_mark[i]   = '0;
            edge_stamp[i]  = '0;
            period_est[i]  = '0;
            stalled[i]     = 1'b0;
            count_down[i]  = 1'b0;
            gen_edge_ts[i] = '0;
            gen_la[i]      = 1'b0;
            gen_lb[i]      = 1'b0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every pin combination on channel 0, first edge counts down through zero
        push_word(CMD_EDGE, 0, 1'b1, 1'b0, 1'b0, 32'd0);
        for (int i = 0; i < 8; i++)
            push_word(CMD_EDGE, 0, i[2], i[1], i[0], gen_edge_ts[0] + 32'd1000);
        // timestamp extremes and wrapped averaging on channel 1
        push_word(CMD_EDGE, 1, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);
        push_word(CMD_EDGE, 1, 1'b1, 1'b1, 1'b1, 32'h0000_0010);
        push_word(CMD_EDGE, 1, 1'b0, 1'b1, 1'b1, gen_edge_ts[1] + 32'd200000);
        // exactly half a second does not time out, a timestamp one greater does
        push_word(CMD_TICK, 1, 1'b0, 1'b0, 1'b0, gen_edge_ts[1] + 32'd300000000);
        push_word(CMD_TICK, 1, 1'b0, 1'b0, 1'b0, gen_edge_ts[1] + 32'd300000001);
        push_word(CMD_EDGE, 1, 1'b1, 1'b0, 1'b1, gen_edge_ts[1] + 32'd5);
        push_word(CMD_TICK, 0, 1'b1, 1'b1, 1'b1, gen_edge_ts[0] + 32'd5);
        push_word(CMD_CLEAR, 1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        push_word(CMD_TICK, 0, 1'b0, 1'b0, 1'b0, gen_edge_ts[0] + 32'd7);
        push_word(CMD_SPARE, 0, 1'b0, 1'b0, 1'b0, 32'd0);
        push_word(CMD_SPARE, 1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        // averaging limits at the default CPM_RESET setting
        push_word(CMD_EDGE, 0, 1'b1, 1'b0, 1'b1, gen_edge_ts[0] + 32'd149999);
        push_word(CMD_EDGE, 0, 1'b1, 1'b1, 1'b1, gen_edge_ts[0] + 32'd150000);
        push_word(CMD_EDGE, 0, 1'b0, 1'b1, 1'b0, gen_edge_ts[0] + 32'd299999);
        push_word(CMD_EDGE, 0, 1'b0, 1'b0, 1'b0, gen_edge_ts[0] + 32'd300000);

        // drain halfway through so the sender stalls on an empty pipeline
        for (int i = 0; i < RANDOM_WORDS / 2; i++)
            random_word();
        wait_idle();
        for (int i = 0; i < RANDOM_WORDS / 2; i++)
            random_word();

        for (int p = 1; p < PHASES; p++) begin
            case (p)
                1:       cpm = 10'd1;
                2:       cpm = 10'd1000;
                3:       cpm = 10'd1023;
                4:       cpm = 10'd0;
                default: cpm = 10'd250;
            endcase
            wait_idle();
            repeat (4) @(posedge i_clk);
            write_config(p[0], cpm);
            for (int i = 0; i < RANDOM_WORDS; i++)
                random_word();
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
